@@ hw/rtl/tbhs_pkg.sv @@
`timescale 1ns / 1ps

package tbhs_pkg;

  // fixed-point formats
  localparam int COUNT_W  = 32;
  localparam int DRIVE_FB = 16;
  localparam int GAIN_FB  = 20;
  localparam int DRIVE_W  = DRIVE_FB + 1;

  // speed divider geometry: numerator 2*|dcount|*scale + dt, denominator 2*dt
  localparam int QUO_W = 24;
  localparam int DEN_W = 33;
  localparam int NUM_W = COUNT_W + 17;

  localparam logic [15:0] DEFAULT_GAIN  = 16'd1049;
  localparam logic [15:0] RPM_SCALE_RST = 16'd24490;

  localparam logic signed [23:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPEED_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_PREDICTED = 3'd1,
    REG_GAIN_CHG  = 3'd2,
    REG_GAIN_STDY = 3'd3,
    REG_RPM_SCALE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/tbhs_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2^QUO_W, so the quotient fits QUO_W bits.
module tbhs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbhs_pkg::div_req_t  req_i,
  output tbhs_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(tbhs_pkg::QUO_W + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [tbhs_pkg::DEN_W-1:0]  rem_q;
  logic [tbhs_pkg::DEN_W-1:0]  den_q;
  logic [tbhs_pkg::QUO_W-1:0]  nlo_q;
  logic [tbhs_pkg::QUO_W-1:0]  quo_q;

  logic [tbhs_pkg::DEN_W+1:0]  trial;
  logic                        borrow;

  assign trial  = {1'b0, rem_q, nlo_q[tbhs_pkg::QUO_W-1]} - {2'b00, den_q};
  assign borrow = trial[tbhs_pkg::DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(tbhs_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= tbhs_pkg::DEN_W'(req_i.num >> tbhs_pkg::QUO_W);
      nlo_q <= req_i.num[tbhs_pkg::QUO_W-1:0];
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      if (borrow) begin
        rem_q <= {rem_q[tbhs_pkg::DEN_W-2:0], nlo_q[tbhs_pkg::QUO_W-1]};
      end else begin
        rem_q <= trial[tbhs_pkg::DEN_W-1:0];
      end
      nlo_q <= {nlo_q[tbhs_pkg::QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[tbhs_pkg::QUO_W-2:0], ~borrow};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hw/rtl/take_back_half_speed_controller.sv @@
`timescale 1ns / 1ps

// Take-back-half wheel speed controller. Each input transfer (encoder count,
// millisecond time) yields one output transfer: motor power 0..127, measured
// speed in Q15.8 rpm, a crossing flag and a zero-interval flag. The speed
// divider yields one quotient bit per cycle, 24 quotient bits in all, and
// hands the quotient over in a registered done flag. A tick with a zero
// interval skips the speed path; a tick whose quotient cannot fit 24 bits
// skips the divider. The input stalls while a tick is in progress; a finished
// result waits in the output register without blocking the next input, but
// that next tick holds in its last step until the waiting result has been
// taken. Configuration writes belong only where no tick is in flight; writing
// target_speed re-arms the crossing logic, drive level is kept.
module take_back_half_speed_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  encoder_count_i,
  input  logic        [31:0]  time_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic        [6:0]   motor_power_o,
  output logic signed [23:0]  speed_o,
  output logic                crossed_o,
  output logic                bad_interval_o,
  input  logic                cfg_we_i,
  input  logic        [2:0]   cfg_idx_i,
  input  logic        [16:0]  cfg_data_i
);

  localparam int CW     = tbhs_pkg::COUNT_W;
  localparam int DW     = tbhs_pkg::DRIVE_W;
  localparam int DFB    = tbhs_pkg::DRIVE_FB;
  localparam int NW     = tbhs_pkg::NUM_W;
  localparam int QW     = tbhs_pkg::QUO_W;
  localparam int EW     = 26;
  localparam int PW     = EW + 17;
  localparam int SHIFT  = 8 + tbhs_pkg::GAIN_FB - DFB;
  localparam int SH_R   = (SHIFT > 0) ? SHIFT : 0;
  localparam int SH_L   = (SHIFT < 0) ? -SHIFT : 0;
  localparam int RND    = (SH_R > 0) ? (1 << (SH_R - 1)) : 0;
  localparam int XW     = PW + SH_L + 1;
  localparam int SW     = XW + 1;
  localparam int CMP_W  = tbhs_pkg::DEN_W + QW;

  localparam logic [DW-1:0]   ONE  = DW'(1) << DFB;
  localparam logic [DW+6:0]   HALF = (DW + 7)'(1) << (DFB - 1);
  localparam logic [QW-1:0]   Q_POS_MAX = QW'(8388607);
  localparam logic [QW-1:0]   Q_NEG_MAX = QW'(8388608);

  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_CHK  = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_SAT  = 9'b000010000,
    ST_ERR  = 9'b000100000,
    ST_MULG = 9'b001000000,
    ST_ACC  = 9'b010000000,
    ST_UPD  = 9'b100000000
  } state_e;

  function automatic logic [1:0] sign_code(input logic signed [EW-1:0] v);
    logic [1:0] s;
    if (v == '0) begin
      s = SGN_ZERO;
    end else if (v[EW-1]) begin
      s = SGN_NEG;
    end else begin
      s = SGN_POS;
    end
    return s;
  endfunction

  function automatic logic [15:0] pick_gain(input logic [15:0] g);
    return (g == '0) ? tbhs_pkg::DEFAULT_GAIN : g;
  endfunction

  function automatic logic signed [EW-1:0] error_of(input logic [12:0] tgt,
                                                    input logic signed [23:0] spd);
    return $signed({{(EW - 21){1'b0}}, tgt, 8'h00}) - {{(EW - 24){spd[23]}}, spd};
  endfunction

  state_e state_q;

  // configuration
  logic [12:0] target_q;
  logic [16:0] pred_q;
  logic [15:0] gain_chg_q;
  logic [15:0] gain_stdy_q;
  logic [15:0] scale_q;

  // controller state
  logic [CW-1:0]        last_cnt_q;
  logic [31:0]          last_time_q;
  logic signed [23:0]   speed_q;
  logic [DW-1:0]        drive_q;
  logic [DW-1:0]        dac_q;
  logic [1:0]           sign_q;
  logic                 await_q;
  logic [15:0]          gain_q;

  // per-tick work registers
  logic signed [CW-1:0] dcnt_q;
  logic [31:0]          dt_q;
  logic                 bad_q;
  logic [NW-1:0]        num_q;
  logic [tbhs_pkg::DEN_W-1:0] den_q;
  logic                 ovf_q;
  logic signed [EW-1:0] err_q;
  logic signed [PW-1:0] prod_q;
  logic signed [XW-1:0] delta_q;

  // output register
  logic                 out_valid_q;
  logic [6:0]           pwr_q;
  logic signed [23:0]   spd_out_q;
  logic                 crossed_q;
  logic                 bad_out_q;

  tbhs_pkg::div_req_t   div_req;
  tbhs_pkg::div_rsp_t   div_rsp;

  logic                 in_xfer;
  logic                 out_free;

  // datapath terms
  logic [CW-1:0]        cnt_mag;
  logic [CW+15:0]       cnt_prod;
  logic                 ovf_now;
  logic signed [23:0]   speed_new;
  logic [PW-1:0]        prod_abs;
  logic [XW-1:0]        inc_mag;
  logic signed [SW-1:0] drive_sum;
  logic [DW-1:0]        drive_clamp;
  logic [DW:0]          drive_avg;
  logic [DW-1:0]        pred_sat;
  logic [1:0]           sign_now;
  logic                 cross_now;
  logic [DW-1:0]        drive_new;
  logic [DW+6:0]        pwr_full;
  logic signed [EW-1:0] cfg_err;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign div_req.start = (state_q == ST_CHK) && !ovf_now;
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  tbhs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    cnt_mag  = dcnt_q[CW-1] ? CW'(-dcnt_q) : CW'(dcnt_q);
    cnt_prod = cnt_mag * scale_q;
    ovf_now  = (CMP_W'(num_q) >= {den_q, {QW{1'b0}}});

    if (!dcnt_q[CW-1]) begin
      speed_new = (ovf_q || (div_rsp.quo > Q_POS_MAX)) ? tbhs_pkg::SPEED_MAX
                                                       : $signed(div_rsp.quo);
    end else begin
      speed_new = (ovf_q || (div_rsp.quo > Q_NEG_MAX)) ? tbhs_pkg::SPEED_MIN
                                                       : $signed(-div_rsp.quo);
    end

    // increment: |err*gain| rounded half away from zero into drive format
    prod_abs = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    inc_mag  = XW'((prod_abs + PW'(RND)) >> SH_R) << SH_L;

    drive_sum = $signed({{(SW - DW){1'b0}}, drive_q}) + {delta_q[XW-1], delta_q};
    if (drive_sum[SW-1]) begin
      drive_clamp = '0;
    end else if (drive_sum > $signed(SW'(ONE))) begin
      drive_clamp = ONE;
    end else begin
      drive_clamp = drive_sum[DW-1:0];
    end

    drive_avg = ({1'b0, drive_clamp} + {1'b0, dac_q} + (DW + 1)'(1)) >> 1;
    pred_sat  = (32'(pred_q) > 32'(ONE)) ? ONE : DW'(pred_q);
    sign_now  = sign_code(err_q);
    cross_now = (sign_now != sign_q);

    if (!cross_now) begin
      drive_new = drive_clamp;
    end else if (await_q) begin
      drive_new = pred_sat;
    end else begin
      drive_new = drive_avg[DW-1:0];
    end

    // drive*127 + half, done as drive*128 - drive
    pwr_full = {drive_new, 7'b0} - (DW + 7)'(drive_new) + HALF;

    cfg_err = error_of(cfg_data_i[12:0], speed_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      pred_q      <= '0;
      gain_chg_q  <= '0;
      gain_stdy_q <= '0;
      scale_q     <= tbhs_pkg::RPM_SCALE_RST;
      last_cnt_q  <= '0;
      last_time_q <= '0;
      speed_q     <= '0;
      drive_q     <= '0;
      dac_q       <= '0;
      sign_q      <= SGN_ZERO;
      await_q     <= 1'b0;
      gain_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            last_cnt_q  <= encoder_count_i[CW-1:0];
            last_time_q <= time_ms_i;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= bad_q ? ST_ERR : ST_CHK;
        end
        ST_CHK: begin
          state_q <= ovf_now ? ST_SAT : ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          speed_q <= speed_new;
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          state_q <= ST_MULG;
        end
        ST_MULG: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            drive_q <= drive_new;
            sign_q  <= sign_now;
            if (cross_now) begin
              dac_q <= drive_new;
              if (await_q) begin
                await_q <= 1'b0;
                if (target_q != '0) begin
                  gain_q <= pick_gain(gain_stdy_q);
                end
              end
            end
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // the user must write only while idle; the block itself does not enforce this
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tbhs_pkg::REG_TARGET: begin
            target_q <= cfg_data_i[12:0];
            sign_q   <= sign_code(cfg_err);
            dac_q    <= '0;
            await_q  <= 1'b1;
            gain_q   <= pick_gain(gain_chg_q);
          end
          tbhs_pkg::REG_PREDICTED: pred_q      <= cfg_data_i;
          tbhs_pkg::REG_GAIN_CHG:  gain_chg_q  <= cfg_data_i[15:0];
          tbhs_pkg::REG_GAIN_STDY: gain_stdy_q <= cfg_data_i[15:0];
          tbhs_pkg::REG_RPM_SCALE: scale_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dcnt_q <= $signed(encoder_count_i[CW-1:0] - last_cnt_q);
        dt_q   <= time_ms_i - last_time_q;
        bad_q  <= (time_ms_i == last_time_q);
      end
      ST_MUL: begin
        num_q <= NW'({cnt_prod, 1'b0}) + NW'(dt_q);
        den_q <= {dt_q, 1'b0};
      end
      ST_CHK: begin
        ovf_q <= ovf_now;
      end
      ST_ERR: begin
        err_q <= error_of(target_q, speed_q);
      end
      ST_MULG: begin
        prod_q <= err_q * $signed({1'b0, gain_q});
      end
      ST_ACC: begin
        delta_q <= prod_q[PW-1] ? $signed(-inc_mag) : $signed(inc_mag);
      end
      ST_UPD: begin
        if (out_free) begin
          pwr_q     <= pwr_full[DFB+6:DFB];
          spd_out_q <= speed_q;
          crossed_q <= cross_now;
          bad_out_q <= bad_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign motor_power_o  = pwr_q;
  assign speed_o        = spd_out_q;
  assign crossed_o      = crossed_q;
  assign bad_interval_o = bad_out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide step");

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q <= ONE)
    else $error("drive level above full power");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_MUL))
    else $error("input transfer did not start a tick");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not posted at end of tick");

endmodule
